[sv/ctp_pkg.sv]
// ----------------------------------------------------------------------------
// ctp_pkg - shared definitions for the contour tick placer
// Field widths, register indices, table size and the sequencer state codes.
// ----------------------------------------------------------------------------
package ctp_pkg;

	// table of tick codes
	localparam int TABLE_ENTRIES = 4;
	localparam int CODE_REGS     = 4;          // tick_code_1 .. tick_code_4
	localparam int ENT_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int MODR_W        = $clog2(TABLE_ENTRIES + 1);

	// field widths
	localparam int COORD_W   = 24;
	localparam int LEVEL_W   = 12;
	localparam int CODE_W    = 3;
	localparam int COUNT_W   = 3;
	localparam int SPACING_W = 24;
	localparam int RUN_W     = 32;

	// arithmetic widths
	localparam int DIFF_W = COORD_W + 1;       // exact coordinate difference
	localparam int MAG_W  = COORD_W;           // magnitude of a difference
	localparam int SQ_W   = 2 * MAG_W;         // one square
	localparam int SUM_W  = SQ_W + 2;          // sum of squares, kept even
	localparam int ROOT_W = SUM_W / 2;         // integer square root
	localparam int REM_W  = ROOT_W + 1;        // remainder, at most 2*root
	localparam int TRY_W  = ROOT_W + 3;        // shifted remainder and trial
	localparam int DIST_W = ROOT_W + 1;        // rounded distance
	localparam int ITER_W = 5;

	localparam int SQR_STEPS  = MAG_W;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int MOD_STEPS  = LEVEL_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SPACING = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CODE1   = 3'd2;

	localparam logic [SPACING_W-1:0] SPACING_RESET = 24'd4096;
	localparam logic [COUNT_W-1:0]   COUNT_RESET   = 3'd1;

	// sequencer
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MOD   = 7'b0000010,
		ST_ABS   = 7'b0000100,
		ST_SQR   = 7'b0001000,
		ST_ROOT  = 7'b0010000,
		ST_ROUND = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

endpackage

[sv/contour_tick_placer.sv]
// ----------------------------------------------------------------------------
// contour_tick_placer - tick mark placement along contour polylines
// Measures the length run along each segment with a bit-serial square and
// square root datapath and marks a point with the segment's tick code each
// time the run reaches the configured spacing.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_stall | segment_start, level, x_coord, y_coord
//  output  | out_valid/out_stall | tick_mark
//  config  | wr_en               | wr_index, wr_data (write only)
//
// One point at a time. A point of a ticked segment passes setup, serial
// squaring, a load and the 25 steps of the bit-pair square root, rounding,
// accumulation and hand-over. A segment start reduces the level one bit a
// cycle; any other point goes straight to hand-over. arst_n clears the
// sequencer, the run state and the registers to their reset values. A
// stalled output beat holds while the next point is accepted and worked
// on; the sequencer waits only to hand over its result.
//
module contour_tick_placer (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             segment_start,
	input  logic [ctp_pkg::LEVEL_W-1:0]      level,
	input  logic signed [ctp_pkg::COORD_W-1:0] x_coord,
	input  logic signed [ctp_pkg::COORD_W-1:0] y_coord,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ctp_pkg::CODE_W-1:0]       tick_mark,
	// configuration
	input  logic                             wr_en,
	input  logic [ctp_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [ctp_pkg::CFG_DATA_W-1:0]   wr_data
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [ctp_pkg::SPACING_W-1:0] spacing_q;
	logic [ctp_pkg::COUNT_W-1:0]   count_q;
	logic [ctp_pkg::CODE_W-1:0]    codes_q [ctp_pkg::TABLE_ENTRIES];
	logic [ctp_pkg::CFG_IDX_W-1:0] code_sel;

	assign code_sel = wr_index - ctp_pkg::REG_CODE1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= ctp_pkg::SPACING_RESET;
			count_q   <= ctp_pkg::COUNT_RESET;
			for (int i = 0; i < ctp_pkg::TABLE_ENTRIES; i++) begin
				codes_q[i] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == ctp_pkg::REG_SPACING) begin
				spacing_q <= wr_data[ctp_pkg::SPACING_W-1:0];
			end else if (wr_index == ctp_pkg::REG_COUNT) begin
				count_q <= wr_data[ctp_pkg::COUNT_W-1:0];
			end else begin
				// code registers past the table or past the list are dropped
				for (int i = 0; i < ctp_pkg::TABLE_ENTRIES; i++) begin
					if (wr_index >= ctp_pkg::REG_CODE1 && i < ctp_pkg::CODE_REGS &&
					    code_sel == ctp_pkg::CFG_IDX_W'(i)) begin
						codes_q[i] <= wr_data[ctp_pkg::CODE_W-1:0];
					end
				end
			end
		end
	end

	// table count in use: zero reads as one, too many as the table size
	logic [ctp_pkg::MODR_W-1:0] count_eff;

	always_comb begin
		if (count_q == '0) begin
			count_eff = ctp_pkg::MODR_W'(1);
		end else if (32'(count_q) > ctp_pkg::TABLE_ENTRIES) begin
			count_eff = ctp_pkg::MODR_W'(ctp_pkg::TABLE_ENTRIES);
		end else begin
			count_eff = ctp_pkg::MODR_W'(count_q);
		end
	end

	// ------------------------------------------------------------------
	// sequencer and run state
	// ------------------------------------------------------------------
	ctp_pkg::state_t state_q;
	logic [ctp_pkg::ITER_W-1:0]  iter_q;
	logic                        out_valid_q;
	logic [ctp_pkg::CODE_W-1:0]  tick_mark_q;

	logic signed [ctp_pkg::COORD_W-1:0] prev_x_q;
	logic signed [ctp_pkg::COORD_W-1:0] prev_y_q;
	logic [ctp_pkg::RUN_W-1:0]   run_q;
	logic                        first_q;
	logic [ctp_pkg::CODE_W-1:0]  seg_code_q;
	logic [ctp_pkg::CODE_W-1:0]  mark_q;

	// datapath registers, no reset needed
	logic [ctp_pkg::LEVEL_W-1:0]  lvl_q;
	logic [ctp_pkg::MODR_W-1:0]   modr_q;
	logic [ctp_pkg::DIFF_W-1:0]   dx_q;
	logic [ctp_pkg::DIFF_W-1:0]   dy_q;
	logic [ctp_pkg::MAG_W-1:0]    ax_q;
	logic [ctp_pkg::MAG_W-1:0]    ay_q;
	logic [ctp_pkg::MAG_W-1:0]    mx_q;
	logic [ctp_pkg::MAG_W-1:0]    my_q;
	logic [ctp_pkg::SQ_W-1:0]     accx_q;
	logic [ctp_pkg::SQ_W-1:0]     accy_q;
	logic [ctp_pkg::SUM_W-1:0]    sq_q;
	logic [ctp_pkg::ROOT_W-1:0]   root_q;
	logic [ctp_pkg::REM_W-1:0]    rem_q;
	logic [ctp_pkg::DIST_W-1:0]   dist_q;
	logic                         sum_ld_q;

	logic accept;
	logic out_free;
	logic out_load;

	assign in_stall  = (state_q != ctp_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ctp_pkg::ST_DONE) && !sum_ld_q && out_free;
	assign out_valid = out_valid_q;
	assign tick_mark = tick_mark_q;

	// level reduction: one bit of the level a cycle, remainder stays below count
	logic [ctp_pkg::MODR_W:0]   mod_try;
	logic [ctp_pkg::MODR_W-1:0] mod_next;
	logic [ctp_pkg::MODR_W-1:0] ent_pick;

	always_comb begin
		mod_try = {modr_q, lvl_q[ctp_pkg::LEVEL_W-1]};
		if (mod_try >= {1'b0, count_eff}) begin
			mod_try = mod_try - {1'b0, count_eff};
		end
		mod_next = mod_try[ctp_pkg::MODR_W-1:0];
		// remainder zero selects the last entry in use
		if (mod_next == '0) begin
			ent_pick = count_eff - ctp_pkg::MODR_W'(1);
		end else begin
			ent_pick = mod_next - ctp_pkg::MODR_W'(1);
		end
	end

	// coordinate differences and their magnitudes
	logic [ctp_pkg::DIFF_W-1:0] dx_new;
	logic [ctp_pkg::DIFF_W-1:0] dy_new;
	logic [ctp_pkg::DIFF_W-1:0] dx_abs;
	logic [ctp_pkg::DIFF_W-1:0] dy_abs;

	assign dx_new = {x_coord[ctp_pkg::COORD_W-1], x_coord} -
	                {prev_x_q[ctp_pkg::COORD_W-1], prev_x_q};
	assign dy_new = {y_coord[ctp_pkg::COORD_W-1], y_coord} -
	                {prev_y_q[ctp_pkg::COORD_W-1], prev_y_q};
	assign dx_abs = dx_q[ctp_pkg::DIFF_W-1] ? (~dx_q + ctp_pkg::DIFF_W'(1)) : dx_q;
	assign dy_abs = dy_q[ctp_pkg::DIFF_W-1] ? (~dy_q + ctp_pkg::DIFF_W'(1)) : dy_q;

	// square root step: bring down the next bit pair, try subtracting 4r+1
	logic [ctp_pkg::TRY_W-1:0] rem_sh;
	logic [ctp_pkg::TRY_W-1:0] trial;
	logic                      take;

	assign rem_sh = {rem_q, sq_q[ctp_pkg::SUM_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	// accumulate the distance, saturate, test against the spacing
	logic [ctp_pkg::RUN_W:0]   run_sum;
	logic [ctp_pkg::RUN_W-1:0] run_sat;
	logic [ctp_pkg::RUN_W:0]   run_cmp;
	logic                      reached;

	always_comb begin
		run_sum = {1'b0, run_q} + (ctp_pkg::RUN_W+1)'(dist_q);
		run_sat = run_sum[ctp_pkg::RUN_W] ? '1 : run_sum[ctp_pkg::RUN_W-1:0];
		// before the first tick compare against half spacing as 2*run
		run_cmp = first_q ? {run_sat, 1'b0} : {1'b0, run_sat};
		reached = (run_cmp >= (ctp_pkg::RUN_W+1)'(spacing_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ctp_pkg::ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
			tick_mark_q <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			run_q       <= '0;
			first_q     <= 1'b1;
			seg_code_q  <= '0;
			mark_q      <= '0;
			sum_ld_q    <= 1'b0;
		end else begin
			// load a fresh output beat, else drop the current one once it is taken
			if (out_load) begin
				tick_mark_q <= mark_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ctp_pkg::ST_IDLE: begin
					if (accept) begin
						prev_x_q <= x_coord;
						prev_y_q <= y_coord;
						mark_q   <= '0;
						if (segment_start) begin
							run_q   <= '0;
							first_q <= 1'b1;
							iter_q  <= '0;
							state_q <= ctp_pkg::ST_MOD;
						end else if (seg_code_q != '0) begin
							state_q <= ctp_pkg::ST_ABS;
						end else begin
							state_q <= ctp_pkg::ST_DONE;
						end
					end
				end
				ctp_pkg::ST_MOD: begin
					iter_q <= iter_q + ctp_pkg::ITER_W'(1);
					if (iter_q == ctp_pkg::ITER_W'(ctp_pkg::MOD_STEPS - 1)) begin
						seg_code_q <= codes_q[ent_pick[ctp_pkg::ENT_W-1:0]];
						state_q    <= ctp_pkg::ST_DONE;
					end
				end
				ctp_pkg::ST_ABS: begin
					iter_q  <= '0;
					state_q <= ctp_pkg::ST_SQR;
				end
				ctp_pkg::ST_SQR: begin
					if (iter_q == ctp_pkg::ITER_W'(ctp_pkg::SQR_STEPS - 1)) begin
						sum_ld_q <= 1'b1;
						iter_q   <= '0;
						state_q  <= ctp_pkg::ST_ROOT;
					end else begin
						iter_q <= iter_q + ctp_pkg::ITER_W'(1);
					end
				end
				ctp_pkg::ST_ROOT: begin
					// while sum_ld_q is set this state only loads the sum of squares
					sum_ld_q <= 1'b0;
					if (!sum_ld_q) begin
						iter_q <= iter_q + ctp_pkg::ITER_W'(1);
						if (iter_q == ctp_pkg::ITER_W'(ctp_pkg::ROOT_STEPS - 1)) begin
							state_q <= ctp_pkg::ST_ROUND;
						end
					end
				end
				ctp_pkg::ST_ROUND: begin
					// dist_q settles here; fold it into the run next
					state_q <= ctp_pkg::ST_DONE;
					mark_q  <= '0;
					sum_ld_q <= 1'b1;
				end
				ctp_pkg::ST_DONE: begin
					if (sum_ld_q) begin
						// accumulate once, then wait for the output register
						sum_ld_q <= 1'b0;
						if (reached) begin
							mark_q  <= seg_code_q;
							run_q   <= '0;
							first_q <= 1'b0;
						end else begin
							run_q <= run_sat;
						end
					end else if (out_free) begin
						state_q <= ctp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ctp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ctp_pkg::ST_IDLE: begin
				lvl_q  <= level;
				modr_q <= '0;
				dx_q   <= dx_new;
				dy_q   <= dy_new;
			end
			ctp_pkg::ST_MOD: begin
				modr_q <= mod_next;
				lvl_q  <= {lvl_q[ctp_pkg::LEVEL_W-2:0], 1'b0};
			end
			ctp_pkg::ST_ABS: begin
				ax_q   <= dx_abs[ctp_pkg::MAG_W-1:0];
				ay_q   <= dy_abs[ctp_pkg::MAG_W-1:0];
				mx_q   <= dx_abs[ctp_pkg::MAG_W-1:0];
				my_q   <= dy_abs[ctp_pkg::MAG_W-1:0];
				accx_q <= '0;
				accy_q <= '0;
			end
			ctp_pkg::ST_SQR: begin
				// shift-add, multiplier bits taken MSB first
				accx_q <= {accx_q[ctp_pkg::SQ_W-2:0], 1'b0} +
				          (mx_q[ctp_pkg::MAG_W-1] ? ctp_pkg::SQ_W'(ax_q) : '0);
				accy_q <= {accy_q[ctp_pkg::SQ_W-2:0], 1'b0} +
				          (my_q[ctp_pkg::MAG_W-1] ? ctp_pkg::SQ_W'(ay_q) : '0);
				mx_q   <= {mx_q[ctp_pkg::MAG_W-2:0], 1'b0};
				my_q   <= {my_q[ctp_pkg::MAG_W-2:0], 1'b0};
			end
			ctp_pkg::ST_ROOT: begin
				if (sum_ld_q) begin
					sq_q   <= ctp_pkg::SUM_W'(accx_q) + ctp_pkg::SUM_W'(accy_q);
					root_q <= '0;
					rem_q  <= '0;
				end else begin
					sq_q <= {sq_q[ctp_pkg::SUM_W-3:0], 2'b00};
					if (take) begin
						rem_q  <= ctp_pkg::REM_W'(rem_sh - trial);
						root_q <= {root_q[ctp_pkg::ROOT_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh[ctp_pkg::REM_W-1:0];
						root_q <= {root_q[ctp_pkg::ROOT_W-2:0], 1'b0};
					end
				end
			end
			ctp_pkg::ST_ROUND: begin
				// round to nearest: a remainder above the root rounds up
				dist_q <= ctp_pkg::DIST_W'(root_q) +
				          ctp_pkg::DIST_W'(rem_q > ctp_pkg::REM_W'(root_q));
			end
			default: begin
				lvl_q <= lvl_q;
			end
		endcase
	end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the contour tick placer
// Streams contour polylines into the point channel, predicts the tick mark of
// every point from a local model of the segment and run-length state, and
// compares each output beat in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat on either channel
	localparam int SETTLE_CYCLES  = 60;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_POINTS   = 140;

	// register indices past the code table: the block must ignore writes to them
	localparam logic [ctp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO =
		ctp_pkg::CFG_IDX_W'(ctp_pkg::REG_CODE1 + ctp_pkg::CODE_REGS);
	localparam logic [ctp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI =
		ctp_pkg::CFG_IDX_W'(ctp_pkg::REG_CODE1 + ctp_pkg::CODE_REGS + 1);

	typedef struct {
		logic                               start;
		logic [ctp_pkg::LEVEL_W-1:0]        lvl;
		logic signed [ctp_pkg::COORD_W-1:0] px;
		logic signed [ctp_pkg::COORD_W-1:0] py;
		logic                               drain;   // hold this point until all marks are back
	} point_t;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic                               segment_start;
	logic [ctp_pkg::LEVEL_W-1:0]        level;
	logic signed [ctp_pkg::COORD_W-1:0] x_coord;
	logic signed [ctp_pkg::COORD_W-1:0] y_coord;
	logic                               out_valid;
	logic                               out_stall;
	logic [ctp_pkg::CODE_W-1:0]         tick_mark;
	logic                               wr_en;
	logic [ctp_pkg::CFG_IDX_W-1:0]      wr_index;
	logic [ctp_pkg::CFG_DATA_W-1:0]     wr_data;

	point_t                     pending_points[$];
	logic [ctp_pkg::CODE_W-1:0] due_marks[$];
	point_t                     cur_point;

	bit in_fired;      // point beat taken at the last rising edge
	bit out_fired;     // mark beat taken at the last rising edge
	bit out_blocked;   // mark beat held back by our stall at the last rising edge
	bit calm;          // no idling on either side
	int send_wait;
	int hold_left;
	int idle_cycles;
	int errors;

	// local copy of the registers and the run state
	logic [ctp_pkg::SPACING_W-1:0]      m_spacing;
	logic [ctp_pkg::COUNT_W-1:0]        m_count;
	logic [ctp_pkg::CODE_W-1:0]         m_codes[1:ctp_pkg::TABLE_ENTRIES];
	logic signed [ctp_pkg::COORD_W-1:0] m_last_x;
	logic signed [ctp_pkg::COORD_W-1:0] m_last_y;
	logic [ctp_pkg::RUN_W-1:0]          m_run;
	logic                               m_before_first;
	logic [ctp_pkg::CODE_W-1:0]         m_seg_code;

	contour_tick_placer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.segment_start (segment_start),
		.level         (level),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tick_mark     (tick_mark),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always #2 clk = ~clk;

	// Euclidean step between two points, rounded to the nearest LSB; a remainder
	// above the floor root rounds up, an equal one does not.
	function automatic longint unsigned step_length(
			logic signed [ctp_pkg::COORD_W-1:0] xa,
			logic signed [ctp_pkg::COORD_W-1:0] ya,
			logic signed [ctp_pkg::COORD_W-1:0] xb,
			logic signed [ctp_pkg::COORD_W-1:0] yb);
		logic signed [ctp_pkg::DIFF_W-1:0] dx;
		logic signed [ctp_pkg::DIFF_W-1:0] dy;
		longint unsigned ax, ay, sq, root, trial;
		dx = ctp_pkg::DIFF_W'(xb) - ctp_pkg::DIFF_W'(xa);
		dy = ctp_pkg::DIFF_W'(yb) - ctp_pkg::DIFF_W'(ya);
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		ax = 64'(dx);
		ay = 64'(dy);
		sq = ax * ax + ay * ay;
		root = 0;
		// the sum of squares stays below 2^50, so the root needs 25 bits
		for (int b = 24; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= sq)
				root = trial;
		end
		if (sq - root * root > root)
			root = root + 1;
		return root;
	endfunction

	// Advance the run state by one point and return the mark it should carry.
	function automatic logic [ctp_pkg::CODE_W-1:0] place_tick(point_t p);
		int unsigned                used;
		int unsigned                entry;
		longint unsigned            total;
		logic                       reached;
		logic [ctp_pkg::CODE_W-1:0] mark;
		mark = '0;
		if (p.start) begin
			// a zero count acts as one, anything past the table as the table size
			if (m_count == 0)
				used = 1;
			else if (32'(m_count) > ctp_pkg::TABLE_ENTRIES)
				used = ctp_pkg::TABLE_ENTRIES;
			else
				used = 32'(m_count);
			entry = 32'(p.lvl) % used;
			if (entry == 0)
				entry = used;
			m_seg_code = m_codes[entry];
			m_run = '0;
			m_before_first = 1'b1;
		end else if (m_seg_code != 0) begin
			total = 64'(m_run) + step_length(m_last_x, m_last_y, p.px, p.py);
			if (total > 64'hFFFF_FFFF)
				total = 64'hFFFF_FFFF;
			m_run = total[ctp_pkg::RUN_W-1:0];
			// half spacing before the first tick, tested as twice the run
			reached = m_before_first ? (2 * total >= 64'(m_spacing))
			                         : (total >= 64'(m_spacing));
			if (reached) begin
				mark = m_seg_code;
				m_run = '0;
				m_before_first = 1'b0;
			end
		end
		m_last_x = p.px;
		m_last_y = p.py;
		return mark;
	endfunction

	task automatic add_point(input logic s, input logic [ctp_pkg::LEVEL_W-1:0] l,
			input logic signed [ctp_pkg::COORD_W-1:0] x,
			input logic signed [ctp_pkg::COORD_W-1:0] y,
			input logic d);
		point_t p;
		p.start = s;
		p.lvl   = l;
		p.px    = x;
		p.py    = y;
		p.drain = d;
		pending_points.push_back(p);
	endtask

	// Write every register, one per cycle; codes are packed {code4..code1}.
	// Unused data bits carry noise, and the spare indices get junk if asked.
	task automatic load_config(input logic [ctp_pkg::SPACING_W-1:0] spacing,
			input logic [ctp_pkg::COUNT_W-1:0] count,
			input logic [4*ctp_pkg::CODE_W-1:0] codes,
			input bit poke_spare);
		logic [ctp_pkg::CFG_IDX_W-1:0]  idx;
		logic [ctp_pkg::CFG_DATA_W-1:0] val;
		for (int r = 0; r <= REG_SPARE_HI; r++) begin
			idx = ctp_pkg::CFG_IDX_W'(r);
			val = ctp_pkg::CFG_DATA_W'($urandom);
			if (idx == ctp_pkg::REG_SPACING)
				val = spacing;
			else if (idx == ctp_pkg::REG_COUNT)
				val[ctp_pkg::COUNT_W-1:0] = count;
			else if (idx < REG_SPARE_LO)
				val[ctp_pkg::CODE_W-1:0] =
					codes[ctp_pkg::CODE_W*(idx-ctp_pkg::REG_CODE1) +: ctp_pkg::CODE_W];
			else if (!poke_spare)
				continue;
			@(negedge clk);
			wr_en    <= 1'b1;
			wr_index <= idx;
			wr_data  <= val;
			case (idx)
				ctp_pkg::REG_SPACING: m_spacing = val;
				ctp_pkg::REG_COUNT: m_count = val[ctp_pkg::COUNT_W-1:0];
				REG_SPARE_LO, REG_SPARE_HI: ;
				default: m_codes[idx - ctp_pkg::REG_CODE1 + 1] = val[ctp_pkg::CODE_W-1:0];
			endcase
		end
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Hold until every point is in and every mark is back, then let the
	// sequencer drain before anything else touches the registers.
	task automatic settle();
		while (pending_points.size() != 0 || in_valid || due_marks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Point driver: present the next point on the falling edge once the last
	// beat has gone, after its drawn gap; a drain point waits for all marks.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fired)) begin
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (pending_points.size() != 0 &&
					!(pending_points[0].drain && due_marks.size() != 0)) begin
				cur_point = pending_points.pop_front();
				in_valid      <= 1'b1;
				segment_start <= cur_point.start;
				level         <= cur_point.lvl;
				x_coord       <= cur_point.px;
				y_coord       <= cur_point.py;
				send_wait = calm ? 0 : int'($urandom_range(0, 4));
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Mark receiver: draw a fresh stall length per beat, count it down only on
	// cycles where it really held a beat back.
	always @(negedge clk) begin
		if (out_fired)
			hold_left = calm ? 0 : int'($urandom_range(0, 4));
		else if (out_blocked && hold_left > 0)
			hold_left--;
		out_stall <= (hold_left > 0);
	end

	// Monitor: check the mark beat first (it always belongs to an older point),
	// then predict the point beat taken at the same edge.
	always @(posedge clk) begin
		logic [ctp_pkg::CODE_W-1:0] want;
		in_fired    = arst_n && in_valid && !in_stall;
		out_fired   = arst_n && out_valid && !out_stall;
		out_blocked = arst_n && out_valid && out_stall;
		if (out_fired) begin
			if (due_marks.size() == 0) begin
				errors++;
				$display("%0t: tick_mark expected none, got %0d", $time, tick_mark);
			end else begin
				want = due_marks.pop_front();
				if (tick_mark !== want) begin
					errors++;
					$display("%0t: tick_mark expected %0d, got %0d", $time, want, tick_mark);
				end
			end
		end
		if (in_fired)
			due_marks.push_back(place_tick(cur_point));
		if (!arst_n || in_fired || out_fired)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [ctp_pkg::SPACING_W-1:0]      sp;
		logic signed [ctp_pkg::COORD_W-1:0] cx;
		logic signed [ctp_pkg::COORD_W-1:0] cy;
		int                                 made;
		int                                 n;
		int                                 reach;
		int                                 delta;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		segment_start = 1'b0;
		level = '0;
		x_coord = '0;
		y_coord = '0;
		out_stall = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		errors = 0;
		idle_cycles = 0;
		send_wait = 0;
		hold_left = 0;
		calm = 1'b1;
		m_spacing = ctp_pkg::SPACING_RESET;
		m_count = ctp_pkg::COUNT_RESET;
		foreach (m_codes[i])
			m_codes[i] = '0;
		m_last_x = '0;
		m_last_y = '0;
		m_run = '0;
		m_before_first = 1'b1;
		m_seg_code = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: unit spacing, three entries, the middle one untick'd.
		load_config(24'd4096, 3'd3, {3'd3, 3'd7, 3'd0, 3'd5}, 1'b0);
		add_point(1'b0, 12'hFFF, 24'sd100, 24'sd100, 1'b0);     // point before any segment
		add_point(1'b1, 12'd0, -24'sd8388608, -24'sd8388608, 1'b0); // level 0 picks the last entry
		add_point(1'b0, 12'd0, 24'sd8388607, 24'sd8388607, 1'b0);   // corner to corner
		add_point(1'b0, 12'd0, 24'sd8388607, 24'sd8388607, 1'b0);   // zero step
		add_point(1'b0, 12'd0, 24'sd8384511, 24'sd8388607, 1'b0);   // exactly one spacing
		add_point(1'b0, 12'd0, 24'sd8380416, 24'sd8388607, 1'b0);   // one LSB short
		add_point(1'b0, 12'd0, 24'sd8380415, 24'sd8388607, 1'b0);   // reaches it
		add_point(1'b1, 12'd1, 24'sd0, 24'sd0, 1'b0);
		add_point(1'b0, 12'd0, 24'sd2048, 24'sd0, 1'b0);           // exactly half spacing
		add_point(1'b1, 12'd4, 24'sd0, 24'sd0, 1'b0);
		add_point(1'b0, 12'd0, 24'sd2047, 24'sd0, 1'b0);           // just under half
		add_point(1'b1, 12'd4095, 24'sd0, 24'sd0, 1'b0);
		add_point(1'b1, 12'd2, 24'sd0, 24'sd0, 1'b1);              // no-tick entry
		add_point(1'b0, 12'd0, 24'sd8388607, -24'sd8388608, 1'b0);
		add_point(1'b0, 12'd0, -24'sd8388608, 24'sd8388607, 1'b0);
		settle();

		// Directed: zero spacing, zero count, junk on the spare indices.
		calm = 1'b0;
		load_config(24'd0, 3'd0, {3'd4, 3'd3, 3'd2, 3'd1}, 1'b1);
		add_point(1'b1, 12'hFFF, 24'sd5, 24'sd5, 1'b0);
		add_point(1'b0, 12'd0, 24'sd5, 24'sd5, 1'b0);              // zero step still ticks
		add_point(1'b0, 12'd0, -24'sd5, 24'sd5, 1'b0);
		settle();

		// Directed: tiny spacing so rounding shows, count above the table.
		load_config(24'd8, 3'd7, {3'd4, 3'd3, 3'd2, 3'd1}, 1'b0);
		add_point(1'b1, 12'd3, 24'sd0, 24'sd0, 1'b0);
		add_point(1'b0, 12'd0, 24'sd1, 24'sd1, 1'b0);              // remainder equals root
		add_point(1'b0, 12'd0, 24'sd3, 24'sd2, 1'b0);
		add_point(1'b0, 12'd0, 24'sd5, 24'sd5, 1'b0);              // remainder above root
		add_point(1'b0, 12'd0, 24'sd5, 24'sd13, 1'b0);
		add_point(1'b1, 12'd8, 24'sd0, 24'sd0, 1'b0);              // level multiple of count
		add_point(1'b0, 12'd0, 24'sd4, 24'sd0, 1'b0);
		settle();

		// Random phases: mostly polylines whose steps are sized to the spacing,
		// with stray points, wild jumps and the odd drain in between.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			calm = (ph % 3 == 2);
			case (ph)
				0: sp = '1;
				1: sp = '0;
				2: sp = 24'd1;
				default: begin
					case ($urandom_range(0, 3))
						0: sp = ctp_pkg::SPACING_W'($urandom);
						1: sp = ctp_pkg::SPACING_W'($urandom_range(2, 64));
						2: sp = 24'd4096;
						default: sp = ctp_pkg::SPACING_W'($urandom_range(4097, 300000));
					endcase
				end
			endcase
			load_config(sp, ctp_pkg::COUNT_W'($urandom_range(0, 7)),
				(4*ctp_pkg::CODE_W)'($urandom), 1'($urandom_range(0, 1)));
			made = 0;
			while (made < PHASE_POINTS) begin
				if ($urandom_range(0, 9) == 0) begin
					add_point(1'($urandom_range(0, 1)), ctp_pkg::LEVEL_W'($urandom),
						ctp_pkg::COORD_W'($urandom), ctp_pkg::COORD_W'($urandom), 1'b0);
					made++;
				end else begin
					cx = ctp_pkg::COORD_W'($urandom);
					cy = ctp_pkg::COORD_W'($urandom);
					add_point(1'b1, ctp_pkg::LEVEL_W'($urandom), cx, cy, 1'b0);
					n = int'($urandom_range(1, 16));
					reach = int'($urandom_range(1,
						((m_spacing == 0) ? 32'd4096 : 32'(m_spacing)) / 3 + 1));
					for (int k = 0; k < n; k++) begin
						if ($urandom_range(0, 11) == 0) begin
							cx = ctp_pkg::COORD_W'($urandom);
							cy = ctp_pkg::COORD_W'($urandom);
						end else begin
							delta = int'($urandom_range(0, 2 * reach)) - reach;
							cx = cx + ctp_pkg::COORD_W'(delta);
							delta = int'($urandom_range(0, 2 * reach)) - reach;
							cy = cy + ctp_pkg::COORD_W'(delta);
						end
						add_point(1'b0, ctp_pkg::LEVEL_W'($urandom), cx, cy,
							$urandom_range(0, 39) == 0);
					end
					made += n + 1;
				end
			end
			settle();
		end

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
